// ===== rtl/tmcs_pkg.sv =====
// Shared types and constants for the texture mip chain size block.
package tmcs_pkg;

  localparam int unsigned TOTAL_W = 48;
  localparam int unsigned ACC_W   = TOTAL_W + 1;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  // saturation marker: one above the largest total
  localparam logic [ACC_W-1:0]   ACC_SAT   = {1'b1, {TOTAL_W{1'b0}}};

  typedef struct packed {
    logic [15:0] base_width;
    logic [15:0] base_height;
    logic [15:0] base_depth;
    logic [15:0] slice_count;
    logic [4:0]  bytes_per_texel;
    logic [5:0]  level_count;
  } tmcs_in_t;

  typedef struct packed {
    logic [47:0] total_bytes;
    logic [4:0]  full_mip_count;
    logic        size_overflow;
  } tmcs_out_t;

  // which factor the shared multiplier takes
  typedef enum logic [1:0] {
    FAC_S = 2'd0,
    FAC_W = 2'd1,
    FAC_H = 2'd2,
    FAC_D = 2'd3
  } fac_t;

  typedef struct packed {
    logic       load;
    logic       mul_lo;
    logic       mul_hi;
    logic       comb;
    logic       accum;
    logic       out_load;
    fac_t       fac;
    logic [4:0] level;
  } tmcs_cmd_t;

  typedef struct packed {
    logic [5:0] n_levels;
  } tmcs_stat_t;

endpackage

// ===== rtl/tmcs_datapath.sv =====
// Datapath: input capture, level dimensions, shared multiplier, accumulator.
module tmcs_datapath #(
  parameter int MAX_LEVELS = 32
) (
  input  logic               clk,
  input  tmcs_pkg::tmcs_in_t  in_data,
  input  tmcs_pkg::tmcs_cmd_t cmd,
  output tmcs_pkg::tmcs_stat_t stat,
  output tmcs_pkg::tmcs_out_t out_data
);
  import tmcs_pkg::*;

  localparam logic [5:0] MaxLv = 6'(MAX_LEVELS);

  tmcs_in_t          in_r;
  logic [ACC_W-1:0]  acc_r;
  logic [47:0]       prod_r;
  logic [47:0]       lo_r;
  logic [20:0]       bs_r;
  logic [TOTAL_W-1:0] total_r;
  logic              over_r;
  tmcs_out_t         out_r;

  // ceil(base / 2^lvl)
  function automatic logic [15:0] level_dim(input logic [15:0] base, input logic [4:0] lvl);
    logic [15:0] q;
    logic [15:0] mask;
    logic        r;
    begin
      if (lvl[4]) begin
        level_dim = {15'b0, |base};
      end else begin
        q    = base >> lvl[3:0];
        mask = (16'h0001 << lvl[3:0]) - 16'h0001;
        r    = |(base & mask);
        level_dim = q + {15'b0, r};
      end
    end
  endfunction

  function automatic logic [4:0] chain_len(input logic [15:0] w, input logic [15:0] h,
                                           input logic [15:0] d);
    logic [15:0] m;
    logic [15:0] x;
    logic [4:0]  len;
    begin
      m = w;
      if (h > m) m = h;
      if (d > m) m = d;
      x   = m - 16'h0001;
      len = 5'd0;
      for (int k = 0; k < 16; k++) begin
        if (x[k]) len = 5'(k + 1);
      end
      chain_len = (m <= 16'h0001) ? 5'd1 : len + 5'd1;
    end
  endfunction

  logic [15:0] fac_val;
  logic [31:0] a_op;
  logic [47:0] prod;
  logic [79:0] full;
  logic        full_sat;
  logic [ACC_W-1:0] sum;

  always_comb begin
    case (cmd.fac)
      FAC_S:   fac_val = in_r.slice_count;
      FAC_W:   fac_val = level_dim(in_r.base_width, cmd.level);
      FAC_H:   fac_val = level_dim(in_r.base_height, cmd.level);
      FAC_D:   fac_val = level_dim(in_r.base_depth, cmd.level);
      default: fac_val = 16'h0000;
    endcase
  end

  assign a_op = cmd.mul_hi ? {15'b0, acc_r[ACC_W-1:32]} : acc_r[31:0];
  assign prod = {16'b0, a_op} * {32'b0, fac_val};

  // after the high pass prod_r holds the upper partial product
  assign full     = {prod_r, 32'b0} + {32'b0, lo_r};
  assign full_sat = |full[79:TOTAL_W];
  assign sum      = {1'b0, total_r} + acc_r;

  assign stat.n_levels = (in_r.level_count > MaxLv) ? MaxLv : in_r.level_count;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r    <= in_data;
      acc_r   <= {{(ACC_W-5){1'b0}}, in_data.bytes_per_texel};
      total_r <= '0;
      over_r  <= 1'b0;
    end
    if (cmd.mul_lo || cmd.mul_hi) begin
      prod_r <= prod;
    end
    if (cmd.mul_hi) begin
      lo_r <= prod_r;
    end
    if (cmd.comb) begin
      acc_r <= full_sat ? ACC_SAT : full[ACC_W-1:0];
      if (cmd.fac == FAC_S) begin
        bs_r <= full[20:0];
      end
    end
    if (cmd.accum) begin
      if (acc_r[ACC_W-1] || sum[ACC_W-1]) begin
        over_r  <= 1'b1;
        total_r <= TOTAL_MAX;
      end else begin
        total_r <= sum[TOTAL_W-1:0];
      end
      // next level starts again from bytes * slices
      acc_r <= {{(ACC_W-21){1'b0}}, bs_r};
    end
    if (cmd.out_load) begin
      out_r.total_bytes    <= total_r;
      out_r.full_mip_count <= chain_len(in_r.base_width, in_r.base_height, in_r.base_depth);
      out_r.size_overflow  <= over_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/tmcs_ctrl.sv =====
// Controller: sequences the multiply passes per level and the output handshake.
module tmcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tmcs_pkg::tmcs_stat_t stat,
  output tmcs_pkg::tmcs_cmd_t  cmd
);
  import tmcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI,
    ST_COMB,
    ST_ACC,
    ST_FIN
  } state_t;

  state_t     state_r, state_nxt;
  fac_t       fac_r, fac_nxt;
  logic [5:0] lvl_r, lvl_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [5:0] lvl_inc;

  assign lvl_inc = lvl_r + 6'd1;

  always_comb begin
    state_nxt     = state_r;
    fac_nxt       = fac_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.fac       = fac_r;
    cmd.level     = lvl_r[4:0];
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          fac_nxt   = FAC_S;
          lvl_nxt   = 6'd0;
          state_nxt = ST_LO;
        end
      end
      ST_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_HI;
      end
      ST_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_COMB;
      end
      ST_COMB: begin
        cmd.comb = 1'b1;
        case (fac_r)
          FAC_S: begin
            fac_nxt   = FAC_W;
            state_nxt = (stat.n_levels == 6'd0) ? ST_FIN : ST_LO;
          end
          FAC_W: begin
            fac_nxt   = FAC_H;
            state_nxt = ST_LO;
          end
          FAC_H: begin
            fac_nxt   = FAC_D;
            state_nxt = ST_LO;
          end
          default: state_nxt = ST_ACC;
        endcase
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        lvl_nxt   = lvl_inc;
        fac_nxt   = FAC_W;
        state_nxt = (lvl_inc == stat.n_levels) ? ST_FIN : ST_LO;
      end
      ST_FIN: begin
        // hand over once the output word is free or leaving
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fac_r       <= FAC_S;
      lvl_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fac_r       <= fac_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/texture_mip_chain_size.sv =====
// Top level of the texture mip chain size block.
// Usage:
//   One input word (base width/height/depth, slice count, bytes per texel,
//   level count) is taken on the in_ channel with valid/ready; one result
//   word (total bytes, full mip count, overflow flag) leaves on the out_
//   channel with valid/ready.
//   The level count is clamped to MAX_LEVELS. One 32x16 multiplier is
//   shared: each 49-bit by 16-bit product needs a low pass, a high pass and
//   a combine step, there are three products per level plus an accumulate
//   step, and bytes times slices is formed once up front. The controller
//   returns to idle after each result and takes no new word before the
//   last one is finished.
//   in_ready is high only while no word is in progress; the next word is
//   accepted while a finished result still waits in the output register.
//   If the receiver stalls, the result holds and the next computation waits
//   at its end until the output register frees up.
//   Reset (rst_n low, synchronous) drops out_valid and returns to idle.
module texture_mip_chain_size #(
  parameter int MAX_LEVELS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tmcs_pkg::tmcs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tmcs_pkg::tmcs_out_t out_data
);
  import tmcs_pkg::*;

  tmcs_cmd_t  cmd;
  tmcs_stat_t stat;

  tmcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tmcs_datapath #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
